/* src/tism_pkg.sv */
// Shared types and constants for the turn indicator state machine.
package tism_pkg;

    localparam int ThrW   = 7;
    localparam int SteerW = 8;
    localparam int ThW    = 7;
    localparam int TimerW = 16;
    localparam int CfgIdxW  = 8;
    localparam int CfgDataW = 16;

    localparam logic [ThW-1:0]    CentreReset = 7'd8;
    localparam logic [ThW-1:0]    BlinkReset  = 7'd50;
    localparam logic [TimerW-1:0] IdleReset   = 16'd100;
    localparam logic [TimerW-1:0] OffReset    = 16'd100;

    localparam logic [CfgIdxW-1:0] REG_CENTRE = 8'd0;
    localparam logic [CfgIdxW-1:0] REG_BLINK  = 8'd1;
    localparam logic [CfgIdxW-1:0] REG_IDLE   = 8'd2;
    localparam logic [CfgIdxW-1:0] REG_OFF    = 8'd3;

    typedef enum logic [3:0] {
        M_NOT_NEUTRAL  = 4'd0,
        M_NEUTRAL_WAIT = 4'd1,
        M_ARMED        = 4'd2,
        M_ARMED_LEFT   = 4'd3,
        M_ARMED_RIGHT  = 4'd4,
        M_LEFT         = 4'd5,
        M_LEFT_WAIT    = 4'd6,
        M_RIGHT        = 4'd7,
        M_RIGHT_WAIT   = 4'd8
    } mode_t;

    typedef struct packed {
        logic [ThW-1:0]    centre;
        logic [ThW-1:0]    blink;
        logic [TimerW-1:0] idle;
        logic [TimerW-1:0] off;
    } cfg_t;

    typedef struct packed {
        logic                     tick;
        logic                     new_data;
        logic [ThrW-1:0]          throttle_abs;
        logic signed [SteerW-1:0] steering_signed;
        logic                     hazard_toggle;
    } item_t;

    typedef struct packed {
        mode_t             mode;
        logic [TimerW-1:0] timer;
        logic              left;
        logic              right;
        logic              hazard;
    } state_t;

endpackage

/* src/tism_cfg.sv */
// Configuration register file: four threshold and timing registers.
module tism_cfg
    import tism_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_data,
    output cfg_t                cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_CENTRE: cfg_next.centre = cfg_data[ThW-1:0];
                REG_BLINK:  cfg_next.blink  = cfg_data[ThW-1:0];
                REG_IDLE:   cfg_next.idle   = cfg_data[TimerW-1:0];
                REG_OFF:    cfg_next.off    = cfg_data[TimerW-1:0];
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.centre <= CentreReset;
            cfg_reg.blink  <= BlinkReset;
            cfg_reg.idle   <= IdleReset;
            cfg_reg.off    <= OffReset;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* src/tism_step.sv */
// Next-state logic: timer tick, one state machine step, hazard toggle.
module tism_step
    import tism_pkg::*;
(
    input  cfg_t   cfg,
    input  item_t  item,
    input  state_t cur,
    output state_t nxt,
    output logic   sync
);

    logic [TimerW-1:0]  timer_tk;
    logic signed [8:0]  st;
    logic signed [8:0]  bt;
    logic signed [8:0]  nbt;
    logic [SteerW-1:0]  st_abs;
    logic               th_hi;
    logic               st_hi;
    logic               dark;
    logic               step_sync;
    state_t             s;

    always_comb
    begin
        timer_tk = (item.tick && cur.timer != '0) ? cur.timer - 1'b1 : cur.timer;
        st       = {item.steering_signed[SteerW-1], item.steering_signed};
        bt       = {2'b00, cfg.blink};
        nbt      = -bt;
        st_abs   = st[8] ? 8'(-st) : st[7:0];
        th_hi    = item.throttle_abs > cfg.centre;
        st_hi    = st_abs > {1'b0, cfg.centre};
        dark     = !cur.left && !cur.right && !cur.hazard;

        s         = cur;
        s.timer   = timer_tk;
        step_sync = 1'b0;

        if (item.new_data)
        begin
            case (cur.mode)
                M_NOT_NEUTRAL:
                begin
                    if (!th_hi && !st_hi)
                    begin
                        s.timer = cfg.idle;
                        s.mode  = M_NEUTRAL_WAIT;
                    end
                end
                M_NEUTRAL_WAIT:
                begin
                    if (th_hi || st_hi)
                    begin
                        s.mode = M_NOT_NEUTRAL; s.left = 1'b0; s.right = 1'b0;
                    end
                    else if (timer_tk == '0)
                        s.mode = M_ARMED;
                end
                M_ARMED:
                begin
                    if (th_hi)
                    begin
                        s.mode = M_NOT_NEUTRAL; s.left = 1'b0; s.right = 1'b0;
                    end
                    else if (st_abs >= {1'b0, cfg.blink})
                    begin
                        s.timer = cfg.idle;
                        s.mode  = st[8] ? M_ARMED_LEFT : M_ARMED_RIGHT;
                    end
                end
                M_ARMED_LEFT:
                begin
                    if (th_hi)
                    begin
                        s.mode = M_NOT_NEUTRAL; s.left = 1'b0; s.right = 1'b0;
                    end
                    else if (st > nbt)
                        s.mode = M_ARMED;
                    else if (timer_tk == '0)
                    begin
                        s.mode    = M_LEFT;
                        step_sync = dark;
                        s.left    = 1'b1;
                    end
                end
                M_ARMED_RIGHT:
                begin
                    if (th_hi)
                    begin
                        s.mode = M_NOT_NEUTRAL; s.left = 1'b0; s.right = 1'b0;
                    end
                    else if (st < bt)
                        s.mode = M_ARMED;
                    else if (timer_tk == '0)
                    begin
                        s.mode    = M_RIGHT;
                        step_sync = dark;
                        s.right   = 1'b1;
                    end
                end
                M_LEFT:
                begin
                    if (st > bt)
                    begin
                        s.mode = M_NOT_NEUTRAL; s.left = 1'b0; s.right = 1'b0;
                    end
                    else if (st > nbt)
                    begin
                        s.timer = cfg.off;
                        s.mode  = M_LEFT_WAIT;
                    end
                end
                M_LEFT_WAIT:
                begin
                    if (st > bt || (st >= nbt && timer_tk == '0))
                    begin
                        s.mode = M_NOT_NEUTRAL; s.left = 1'b0; s.right = 1'b0;
                    end
                    else if (st < nbt)
                        s.mode = M_LEFT;
                end
                M_RIGHT:
                begin
                    if (st < nbt)
                    begin
                        s.mode = M_NOT_NEUTRAL; s.left = 1'b0; s.right = 1'b0;
                    end
                    else if (st < bt)
                    begin
                        s.timer = cfg.off;
                        s.mode  = M_RIGHT_WAIT;
                    end
                end
                M_RIGHT_WAIT:
                begin
                    if (st < nbt || (st <= bt && timer_tk == '0))
                    begin
                        s.mode = M_NOT_NEUTRAL; s.left = 1'b0; s.right = 1'b0;
                    end
                    else if (st > bt)
                        s.mode = M_RIGHT;
                end
                default:
                    s.mode = M_NOT_NEUTRAL;
            endcase
        end

        // hazard toggle looks at the flags left by the step
        sync = step_sync;
        if (item.hazard_toggle)
        begin
            if (!s.left && !s.right && !s.hazard)
                sync = 1'b1;
            s.hazard = !s.hazard;
        end

        nxt = s;
    end

endmodule

/* src/turn_indicator_state_machine_core.sv */
// Top level of the turn indicator state machine: stream ports and pipeline registers.
//
// Usage:
//   s_* is the input stream. One beat carries tick, new_data, throttle
//   magnitude, signed steering and a hazard toggle request. m_* is the
//   result stream: exactly one beat per input beat, in order, giving the
//   indicator flags, the hazard flag, a blink sync pulse and the mode.
//   cfg_* writes the four threshold and timing registers (index 0..3,
//   other indexes ignored); cfg_ready is always high. Write them while the
//   block is idle.
//   The beat taken sits in the input register; its result is registered
//   on m_* from there once the result register is free or being drained.
//   Throughput: one beat per cycle while m_tready is high; the next-state
//   logic is a single pass of compares and one 16-bit decrement between
//   the input register and the result register.
//   Receiver stall: the result register holds while m_tready is low, the
//   input register takes one more beat if it is empty, then s_tready drops.
//   Reset: rst_n (async, active low) empties both registers, clears mode,
//   timer and flags, and loads the register defaults (8, 50, 100, 100).
module turn_indicator_state_machine_core
    import tism_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // config write channel
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_data,
    // input stream
    input  logic                s_tvalid,
    output logic                s_tready,
    // [0] tick, [1] new_data, [8:2] throttle_abs, [16:9] steering_signed,
    // [17] hazard_toggle, [23:18] zero
    input  logic [23:0]         s_tdata,
    // result stream
    output logic                m_tvalid,
    input  logic                m_tready,
    // [0] left_on, [1] right_on, [2] hazard_on, [3] blink_sync, [7:4] mode
    output logic [7:0]          m_tdata
);

    cfg_t   cfg;
    item_t  in_item;
    state_t cur;
    state_t nxt;
    logic   sync;

    logic   in_valid_reg;
    item_t  in_data_reg;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic [7:0] out_data_reg;
    state_t state_reg;
    logic   advance;

    assign cfg_ready = 1'b1;

    tism_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // unpack the input beat
    always_comb
    begin
        in_item.tick            = s_tdata[0];
        in_item.new_data        = s_tdata[1];
        in_item.throttle_abs    = s_tdata[8:2];
        in_item.steering_signed = s_tdata[16:9];
        in_item.hazard_toggle   = s_tdata[17];
    end

    // the held item moves on when the result slot is free or being drained
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign cur      = state_reg;

    tism_step u_step (
        .cfg  (cfg),
        .item (in_data_reg),
        .cur  (cur),
        .nxt  (nxt),
        .sync (sync)
    );

    assign out_valid_next = advance || (out_valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            state_reg.mode   <= M_NOT_NEUTRAL;
            state_reg.timer  <= '0;
            state_reg.left   <= 1'b0;
            state_reg.right  <= 1'b0;
            state_reg.hazard <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            out_valid_reg <= out_valid_next;
            if (advance)
                state_reg <= nxt;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            in_data_reg <= in_item;
        if (advance)
            out_data_reg <= {nxt.mode, sync, nxt.hazard, nxt.right, nxt.left};
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

/* bench/turn_indicator_checker.sv */
`timescale 1ns / 100ps
// Checker for the turn indicator core: predicts each result beat and compares it.
module turn_indicator_checker
    import tism_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_data,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [23:0]         s_tdata,
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [7:0]          m_tdata,
    output int                  mismatches,
    output int                  pending,
    output int                  checked,
    output logic [15:0]         modes_seen
);

    // m_tdata seen as a struct, lowest bit first: left, right, hazard, sync, mode
    typedef struct packed {
        logic [3:0] mode;
        logic       sync;
        logic       hazard;
        logic       right;
        logic       left;
    } lamps_t;

    lamps_t            lamps_due[$];

    // predicted block state and register copies
    mode_t             pred_mode;
    logic [TimerW-1:0] pred_timer;
    logic              pred_left;
    logic              pred_right;
    logic              pred_hazard;
    logic [ThW-1:0]    cfg_centre;
    logic [ThW-1:0]    cfg_blink;
    logic [TimerW-1:0] cfg_idle;
    logic [TimerW-1:0] cfg_off;

    task automatic flag_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        mismatches++;
    endtask

    task automatic compare_field(input string name, input logic [3:0] got,
                                 input logic [3:0] want);
        if (got !== want)
            flag_mismatch($sformatf("result %0d %s got %0d want %0d",
                                    checked, name, got, want));
    endtask

    function automatic item_t decode_beat(input logic [23:0] d);
        item_t it;
        it.tick            = d[0];
        it.new_data        = d[1];
        it.throttle_abs    = d[8:2];
        it.steering_signed = d[16:9];
        it.hazard_toggle   = d[17];
        return it;
    endfunction

    function automatic logic all_dark();
        return !pred_left && !pred_right && !pred_hazard;
    endfunction

    task automatic drop_to_not_neutral();
        pred_mode  = M_NOT_NEUTRAL;
        pred_left  = 1'b0;
        pred_right = 1'b0;
    endtask

    task automatic apply_cfg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
        case (idx)
            REG_CENTRE: cfg_centre = data[ThW-1:0];
            REG_BLINK:  cfg_blink  = data[ThW-1:0];
            REG_IDLE:   cfg_idle   = data;
            REG_OFF:    cfg_off    = data;
            default:    ;
        endcase
    endtask

    // One input beat: tick first, then a state step on new data, then hazard.
    task automatic step_lamps(input item_t it, output lamps_t res);
        int   ct;
        int   bt;
        int   th;
        int   st;
        int   mag;
        logic sync;
        ct   = int'(cfg_centre);
        bt   = int'(cfg_blink);
        th   = int'(it.throttle_abs);
        st   = int'($signed(it.steering_signed));
        mag  = (st < 0) ? -st : st;
        sync = 1'b0;

        if (it.tick && pred_timer != '0)
            pred_timer = pred_timer - 1'b1;

        if (it.new_data) begin
            case (pred_mode)
                M_NOT_NEUTRAL: begin
                    if (th <= ct && mag <= ct) begin
                        pred_timer = cfg_idle;
                        pred_mode  = M_NEUTRAL_WAIT;
                    end
                end
                M_NEUTRAL_WAIT: begin
                    if (th > ct || mag > ct)
                        drop_to_not_neutral();
                    else if (pred_timer == '0)
                        pred_mode = M_ARMED;
                end
                M_ARMED: begin
                    if (th > ct)
                        drop_to_not_neutral();
                    else if (mag >= bt) begin
                        pred_timer = cfg_idle;
                        pred_mode  = (st < 0) ? M_ARMED_LEFT : M_ARMED_RIGHT;
                    end
                end
                M_ARMED_LEFT: begin
                    if (th > ct)
                        drop_to_not_neutral();
                    else if (st > -bt)
                        pred_mode = M_ARMED;
                    else if (pred_timer == '0) begin
                        pred_mode = M_LEFT;
                        if (all_dark())
                            sync = 1'b1;
                        pred_left = 1'b1;
                    end
                end
                M_ARMED_RIGHT: begin
                    if (th > ct)
                        drop_to_not_neutral();
                    else if (st < bt)
                        pred_mode = M_ARMED;
                    else if (pred_timer == '0) begin
                        pred_mode = M_RIGHT;
                        if (all_dark())
                            sync = 1'b1;
                        pred_right = 1'b1;
                    end
                end
                M_LEFT: begin
                    if (st > bt)
                        drop_to_not_neutral();
                    else if (st > -bt) begin
                        pred_timer = cfg_off;
                        pred_mode  = M_LEFT_WAIT;
                    end
                end
                M_LEFT_WAIT: begin
                    if (st > bt)
                        drop_to_not_neutral();
                    else if (st < -bt)
                        pred_mode = M_LEFT;
                    else if (pred_timer == '0)
                        drop_to_not_neutral();
                end
                M_RIGHT: begin
                    if (st < -bt)
                        drop_to_not_neutral();
                    else if (st < bt) begin
                        pred_timer = cfg_off;
                        pred_mode  = M_RIGHT_WAIT;
                    end
                end
                M_RIGHT_WAIT: begin
                    if (st < -bt)
                        drop_to_not_neutral();
                    else if (st > bt)
                        pred_mode = M_RIGHT;
                    else if (pred_timer == '0)
                        drop_to_not_neutral();
                end
                default: pred_mode = M_NOT_NEUTRAL;
            endcase
        end

        if (it.hazard_toggle) begin
            if (all_dark())
                sync = 1'b1;
            pred_hazard = !pred_hazard;
        end

        res.left   = pred_left;
        res.right  = pred_right;
        res.hazard = pred_hazard;
        res.sync   = sync;
        res.mode   = pred_mode;
    endtask

    always @(posedge clk or negedge rst_n) begin : watch
        lamps_t want;
        lamps_t got;
        if (!rst_n) begin
            lamps_due.delete();
            pred_mode   = M_NOT_NEUTRAL;
            pred_timer  = '0;
            pred_left   = 1'b0;
            pred_right  = 1'b0;
            pred_hazard = 1'b0;
            cfg_centre  = CentreReset;
            cfg_blink   = BlinkReset;
            cfg_idle    = IdleReset;
            cfg_off     = OffReset;
            mismatches  = 0;
            pending     = 0;
            checked     = 0;
            modes_seen  = '0;
        end else begin
            // result side first: a beat leaving now belongs to an older input
            if (m_tvalid && m_tready) begin
                if (lamps_due.size() == 0)
                    flag_mismatch($sformatf("result %0d with nothing expected", checked));
                else begin
                    want = lamps_due.pop_front();
                    got  = lamps_t'(m_tdata);
                    compare_field("left_on", {3'b000, got.left}, {3'b000, want.left});
                    compare_field("right_on", {3'b000, got.right}, {3'b000, want.right});
                    compare_field("hazard_on", {3'b000, got.hazard},
                                  {3'b000, want.hazard});
                    compare_field("blink_sync", {3'b000, got.sync}, {3'b000, want.sync});
                    compare_field("mode", got.mode, want.mode);
                    if (!$isunknown(got.mode))
                        modes_seen[got.mode] = 1'b1;
                end
                checked++;
            end
            if (cfg_valid && cfg_ready)
                apply_cfg(cfg_index, cfg_data);
            if (s_tvalid && s_tready) begin
                step_lamps(decode_beat(s_tdata), want);
                lamps_due.push_back(want);
            end
            pending = lamps_due.size();
        end
    end

endmodule

/* bench/tb_turn_indicator_state_machine_core.sv */
`timescale 1ns / 100ps
// Testbench top for the turn indicator core: clock, reset, stimulus and verdict.
module tb_turn_indicator_state_machine_core;
    import tism_pkg::*;

    // Indexes outside the register list; the block must ignore writes to them.
    localparam logic [CfgIdxW-1:0] REG_NONE_LOW  = 8'd4;
    localparam logic [CfgIdxW-1:0] REG_NONE_HIGH = 8'hFF;

    // Cycles with no beat on any channel before the run is declared hung.
    localparam int StallLimit = 2000;

    // Driving patterns for the random part, each held for a short run of beats.
    typedef enum int {
        HOLD_NEUTRAL,
        HOLD_LEFT,
        HOLD_RIGHT,
        HOLD_LOOSE,
        HOLD_NOISE
    } drive_t;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CfgIdxW-1:0]  cfg_index = '0;
    logic [CfgDataW-1:0] cfg_data  = '0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    // [0] tick, [1] new_data, [8:2] throttle_abs, [16:9] steering_signed,
    // [17] hazard_toggle, [23:18] zero
    logic [23:0]         s_tdata   = '0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    // [0] left_on, [1] right_on, [2] hazard_on, [3] blink_sync, [7:4] mode
    logic [7:0]          m_tdata;

    int                  mismatches;
    int                  pending;
    int                  checked;
    logic [15:0]         modes_seen;

    // handshake outcomes of the last rising edge, read at the falling edge
    logic                s_took    = 1'b0;
    logic                cfg_took  = 1'b0;
    logic                quiet     = 1'b0;   // no idling on either side
    int                  stall_cycles = 0;
    int                  beats_sent   = 0;
    int                  settings_run = 1;   // reset defaults count as one
    int                  cur_centre   = CentreReset;
    int                  cur_blink    = BlinkReset;

    turn_indicator_state_machine_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    turn_indicator_checker lamp_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .mismatches (mismatches),
        .pending    (pending),
        .checked    (checked),
        .modes_seen (modes_seen)
    );

    // 20 ns period
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Sample both input-side handshakes at the rising edge, before any
    // register in the block has updated.
    always @(posedge clk)
    begin
        s_took   <= s_tvalid && s_tready;
        cfg_took <= cfg_valid && cfg_ready;
    end

    // Result side: stall with a chance of 7 in 100, never while quiet.
    always @(negedge clk)
    begin
        m_tready <= quiet || ($urandom_range(0, 99) >= 7);
    end

    // Watchdog: any beat on any channel resets the count.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else if (stall_cycles >= StallLimit)
        begin
            $display("Watchdog: no beat for %0d cycles, %0d results outstanding",
                     stall_cycles, pending);
            $display("FAILURE");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // One input beat. Called and returns at a falling edge; tvalid is left
    // high so a following beat can go out with no gap.
    task automatic send_beat(input logic tk, input logic nd, input logic [6:0] thr,
                             input logic [7:0] st, input logic hz);
        if (!quiet)
            while ($urandom_range(0, 99) < 7)
            begin
                s_tvalid <= 1'b0;
                @(negedge clk);
            end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, hz, st, thr, nd, tk};
        do
            @(negedge clk);
        while (!s_took);
        beats_sent++;
    endtask

    // Lower tvalid, let every expected result come out, then let the clock run on.
    task automatic settle();
        s_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        repeat (3) @(negedge clk);
    endtask

    // One config beat; cfg_valid is left high for the next write.
    task automatic put_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(negedge clk);
        while (!cfg_took);
    endtask

    // Full register setting, plus one write to an index that must be ignored.
    task automatic apply_settings(input logic [CfgDataW-1:0] centre,
                                  input logic [CfgDataW-1:0] blink,
                                  input logic [CfgDataW-1:0] idle,
                                  input logic [CfgDataW-1:0] off);
        settle();
        put_reg(REG_CENTRE, centre);
        put_reg(REG_BLINK, blink);
        put_reg(REG_IDLE, idle);
        put_reg(REG_OFF, off);
        if (settings_run % 2 == 1)
            put_reg(REG_NONE_HIGH, 16'hFFFF);
        else
            put_reg(REG_NONE_LOW, CfgDataW'($urandom));
        cfg_valid  <= 1'b0;
        cur_centre = centre[ThW-1:0];
        cur_blink  = blink[ThW-1:0];
        settings_run++;
    endtask

    function automatic logic [7:0] pick_steer(input drive_t kind);
        int v;
        case (kind)
            HOLD_NEUTRAL: v = int'($urandom_range(0, 2 * cur_centre)) - cur_centre;
            HOLD_LEFT:    v = -128 + int'($urandom_range(0, 128 - cur_blink));
            HOLD_RIGHT:   v = int'($urandom_range(cur_blink, 127));
            HOLD_LOOSE:   v = int'($urandom_range(0, 2 * cur_blink)) - cur_blink;
            default:      v = int'($urandom_range(0, 255));
        endcase
        return v[7:0];
    endfunction

    function automatic logic [6:0] pick_throttle(input drive_t kind);
        if (kind == HOLD_NOISE || $urandom_range(0, 99) < 10)
            return 7'($urandom_range(0, 127));
        return 7'($urandom_range(0, cur_centre));
    endfunction

    // Random driving: runs of neutral, held left, held right, loose steering
    // and noise, with random ticks, data gaps and the odd hazard toggle.
    task automatic run_random(input int count);
        int     remaining;
        int     r;
        int     span;
        drive_t kind;
        remaining = count;
        while (remaining > 0)
        begin
            r    = $urandom_range(0, 99);
            kind = (r < 30) ? HOLD_NEUTRAL :
                   (r < 50) ? HOLD_LEFT    :
                   (r < 70) ? HOLD_RIGHT   :
                   (r < 82) ? HOLD_LOOSE   : HOLD_NOISE;
            span = $urandom_range(1, 10);
            for (int k = 0; k < span && remaining > 0; k++)
            begin
                send_beat($urandom_range(0, 99) < 60, $urandom_range(0, 99) < 85,
                          pick_throttle(kind), pick_steer(kind),
                          $urandom_range(0, 99) < 3);
                remaining--;
            end
        end
    endtask

    initial
    begin
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // Reset defaults first: long idle time, so mostly the neutral states.
        run_random(100);

        // Directed walk with zero idle time and a one-tick off timeout.
        apply_settings(16'd8, 16'd50, 16'd0, 16'd1);
        send_beat(1'b0, 1'b1, 7'd127, 8'sd127, 1'b0);  // full throttle: not neutral
        send_beat(1'b1, 1'b1, 7'd0, 8'sd0, 1'b0);      // neutral, timer loaded with 0
        send_beat(1'b0, 1'b1, 7'd8, -8'sd8, 1'b0);     // neutral at threshold: armed
        send_beat(1'b0, 1'b1, 7'd0, -8'sd128, 1'b0);   // hardest left: armed left
        send_beat(1'b0, 1'b1, 7'd0, -8'sd128, 1'b0);   // left starts, sync from dark
        send_beat(1'b0, 1'b1, 7'd0, 8'sd0, 1'b0);      // released: left wait
        send_beat(1'b0, 1'b1, 7'd0, -8'sd51, 1'b0);    // back to held left
        send_beat(1'b0, 1'b1, 7'd0, 8'sd0, 1'b0);      // left wait again
        send_beat(1'b1, 1'b1, 7'd0, 8'sd0, 1'b0);      // off timeout: cancel
        send_beat(1'b1, 1'b0, 7'd0, 8'sd0, 1'b1);      // hazard with no data step
        send_beat(1'b1, 1'b0, 7'd0, 8'sd0, 1'b1);      // hazard off again
        send_beat(1'b1, 1'b0, 7'd127, 8'sd127, 1'b0);  // tick only, timer stays at zero
        send_beat(1'b0, 1'b1, 7'd0, 8'sd0, 1'b0);      // neutral wait
        send_beat(1'b0, 1'b1, 7'd0, 8'sd0, 1'b0);      // armed
        send_beat(1'b0, 1'b1, 7'd0, 8'sd50, 1'b0);     // right at threshold: armed right
        send_beat(1'b0, 1'b1, 7'd0, 8'sd49, 1'b0);     // just under: back to armed
        send_beat(1'b0, 1'b1, 7'd0, 8'sd127, 1'b0);    // armed right
        send_beat(1'b0, 1'b1, 7'd0, 8'sd127, 1'b1);    // right starts, hazard too
        send_beat(1'b0, 1'b1, 7'd0, 8'sd10, 1'b0);     // right wait
        send_beat(1'b0, 1'b1, 7'd0, 8'sd51, 1'b0);     // back to right
        send_beat(1'b0, 1'b1, 7'd0, -8'sd128, 1'b1);   // opposite steering cancels
        send_beat(1'b0, 1'b1, 7'd9, 8'sd0, 1'b0);      // throttle just over neutral
        send_beat(1'b1, 1'b1, 7'd0, -8'sd9, 1'b0);     // steering just over neutral

        apply_settings(16'd8, 16'd50, 16'd2, 16'd3);
        run_random(300);

        // All registers zero: only zero input is neutral; run with no idling at all.
        apply_settings(16'd0, 16'd0, 16'd0, 16'd0);
        quiet = 1'b1;
        run_random(150);
        settle();
        quiet = 1'b0;

        // Idle zero, the rest at the top; junk in the unused bits of the 7-bit registers.
        apply_settings(16'hFFFF, 16'hFF7F, 16'd0, 16'hFFFF);
        run_random(150);

        apply_settings(16'd100, 16'd100, 16'd1, 16'd2);
        run_random(150);

        apply_settings(16'd20, 16'd30, 16'hFFFF, 16'd0);
        run_random(100);

        apply_settings(16'd50, 16'd10, 16'd3, 16'd1);
        run_random(250);

        settle();

        $display("Run covered %0d input beats under %0d register settings, %0d results checked.",
                 beats_sent, settings_run, checked);
        $display("Modes seen on the result stream (bit per mode, lowest first): %b",
                 modes_seen[8:0]);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

/* turn_indicator_state_machine_core.f */
src/tism_pkg.sv
src/tism_cfg.sv
src/tism_step.sv
src/turn_indicator_state_machine_core.sv
bench/turn_indicator_checker.sv
bench/tb_turn_indicator_state_machine_core.sv
